### rtl/nlp_pkg.sv
package nlp_pkg;

    // Character codes that steer the parse.
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_F    = 8'h46;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Largest magnitude that can still take a decimal digit without overflow.
    localparam logic [63:0] DEC_LIMIT = 64'd1844674407370955161;
    localparam logic [3:0]  DEC_LIMIT_DIGIT = 4'd5;
    // Magnitude of the most negative signed value.
    localparam logic [63:0] SIGNED_MIN_MAG = 64'h8000_0000_0000_0000;

    // Configuration port.
    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] REG_SIGNED_MODE = 3'd0;

    typedef enum logic [1:0] {
        PH_START      = 2'd0,
        PH_AFTER_SIGN = 2'd1,
        PH_AFTER_ZERO = 2'd2,
        PH_BODY       = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_DIGITS = 3'd1,
        ST_BAD_BASE  = 3'd2,
        ST_BAD_DIGIT = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

endpackage

### rtl/numeric_literal_parser.sv
// A closing character goes from the input register into the result register
// and waits in the input register while the previous result is still stalled.
// Throughput: one character per cycle while no result stalls the input; the
// per-character step (shift, or multiply by ten and add, with the overflow
// compare) sits between the input register and the result register. Reset
// (rst_n low, asynchronous) clears the parse state, both valid flags and
// signed_mode.
module numeric_literal_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    // Character channel.
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  char_code,
    input  logic                        is_last,
    // Result channel.
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [63:0]                 value,
    output logic [2:0]                  status,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nlp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import nlp_pkg::*;

    logic        signed_mode_reg;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;

    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    radix_t      radix_reg, radix_next;
    logic [63:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    status_t     err_reg, err_next;
    logic        seen_reg, seen_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] value_reg, value_next;
    status_t     status_reg, status_next;

    logic        proc;
    logic        in_accept;
    logic        is_dec, is_lower, is_upper;
    logic [3:0]  digit;
    logic        digit_ok;
    logic [63:0] body_acc;
    logic        body_ovf;
    status_t     body_err;
    logic        body_seen;
    logic        do_body;
    logic [63:0] final_value;
    status_t     final_status;

    // Configuration register, written in the access phase of a write.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_SIGNED_MODE) ? {31'b0, signed_mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr == REG_SIGNED_MODE)
        begin
            signed_mode_reg <= pwdata[0];
        end
    end

    // The held character moves on unless it closes a literal while the
    // previous result is still stalled.
    assign proc      = in_valid_reg && !(in_last_reg && out_valid_reg && out_stall);
    assign in_stall  = in_valid_reg && !proc;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Digit value of the held character in the current radix.
    always_comb
    begin
        is_dec   = in_char_reg >= CH_ZERO && in_char_reg <= CH_NINE;
        is_lower = in_char_reg >= CH_LOWER_A && in_char_reg <= CH_LOWER_F;
        is_upper = in_char_reg >= CH_UPPER_A && in_char_reg <= CH_UPPER_F;
        digit    = 4'd0;
        if (is_dec)
        begin
            digit = 4'(in_char_reg - CH_ZERO);
        end
        else if (is_lower)
        begin
            digit = 4'(in_char_reg - CH_LOWER_A + 8'd10);
        end
        else if (is_upper)
        begin
            digit = 4'(in_char_reg - CH_UPPER_A + 8'd10);
        end
        case (radix_reg)
            RADIX_BIN: digit_ok = is_dec && digit <= 4'd1;
            RADIX_HEX: digit_ok = is_dec || is_lower || is_upper;
            default:   digit_ok = is_dec;
        endcase
    end

    // One body character: skip underscores, keep the first error, otherwise
    // shift the digit in (or multiply by ten and add it) and note any overflow.
    always_comb
    begin
        body_acc  = acc_reg;
        body_ovf  = ovf_reg;
        body_err  = err_reg;
        body_seen = seen_reg;
        if (in_char_reg != CH_UNDERSCORE)
        begin
            body_seen = 1'b1;
            if (err_reg == ST_OK)
            begin
                if (!digit_ok)
                begin
                    body_err = ST_BAD_DIGIT;
                end
                else
                begin
                    case (radix_reg)
                        RADIX_BIN:
                        begin
                            body_ovf = ovf_reg || acc_reg[63];
                            body_acc = {acc_reg[62:0], digit[0]};
                        end
                        RADIX_HEX:
                        begin
                            body_ovf = ovf_reg || (acc_reg[63:60] != 4'd0);
                            body_acc = {acc_reg[59:0], digit};
                        end
                        default:
                        begin
                            body_ovf = ovf_reg || acc_reg > DEC_LIMIT
                                || (acc_reg == DEC_LIMIT && digit > DEC_LIMIT_DIGIT);
                            body_acc = {acc_reg[60:0], 3'b0} + {acc_reg[62:0], 1'b0}
                                + {60'b0, digit};
                        end
                    endcase
                end
            end
        end
    end

    // Phase sequencing for the held character.
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        err_next   = err_reg;
        seen_next  = seen_reg;
        do_body    = 1'b0;
        unique case (phase_reg) inside
            PH_START, PH_AFTER_SIGN:
            begin
                if (phase_reg == PH_START && in_char_reg == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_AFTER_SIGN;
                end
                else if (in_char_reg == CH_ZERO)
                begin
                    seen_next  = 1'b1;
                    acc_next   = 64'd0;
                    phase_next = PH_AFTER_ZERO;
                end
                else
                begin
                    phase_next = PH_BODY;
                    do_body    = 1'b1;
                end
            end
            PH_AFTER_ZERO:
            begin
                phase_next = PH_BODY;
                if (in_char_reg == CH_LOWER_B)
                begin
                    radix_next = RADIX_BIN;
                    seen_next  = 1'b0;
                end
                else if (in_char_reg == CH_LOWER_X)
                begin
                    radix_next = RADIX_HEX;
                    seen_next  = 1'b0;
                end
                else
                begin
                    err_next = ST_BAD_BASE;
                end
            end
            default:
            begin
                do_body = 1'b1;
            end
        endcase
        if (do_body)
        begin
            acc_next  = body_acc;
            ovf_next  = body_ovf;
            err_next  = body_err;
            seen_next = body_seen;
        end
    end

    // Result of the finished literal: first error, missing digits, or range check.
    always_comb
    begin
        final_value  = 64'd0;
        final_status = ST_OK;
        if (err_next != ST_OK)
        begin
            final_status = err_next;
        end
        else if (!seen_next)
        begin
            final_status = ST_NO_DIGITS;
        end
        else if (!signed_mode_reg)
        begin
            if (ovf_next || (neg_next && acc_next != 64'd0))
            begin
                final_status = ST_RANGE;
            end
            else
            begin
                final_value = acc_next;
            end
        end
        else if (ovf_next)
        begin
            final_status = ST_RANGE;
        end
        else if (!neg_next)
        begin
            if (acc_next[63])
            begin
                final_status = ST_RANGE;
            end
            else
            begin
                final_value = acc_next;
            end
        end
        else if (acc_next[63] && acc_next != SIGNED_MIN_MAG)
        begin
            final_status = ST_RANGE;
        end
        else
        begin
            final_value = 64'd0 - acc_next;
        end
    end

    // Result register: loaded by a closing character, freed when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (proc && in_last_reg)
        begin
            out_valid_next = 1'b1;
            value_next     = final_value;
            status_next    = final_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            neg_reg       <= 1'b0;
            radix_reg     <= RADIX_DEC;
            acc_reg       <= 64'd0;
            ovf_reg       <= 1'b0;
            err_reg       <= ST_OK;
            seen_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc)
            begin
                if (in_last_reg)
                begin
                    // A literal is closed: start the next one clean.
                    phase_reg <= PH_START;
                    neg_reg   <= 1'b0;
                    radix_reg <= RADIX_DEC;
                    acc_reg   <= 64'd0;
                    ovf_reg   <= 1'b0;
                    err_reg   <= ST_OK;
                    seen_reg  <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    radix_reg <= radix_next;
                    acc_reg   <= acc_next;
                    ovf_reg   <= ovf_next;
                    err_reg   <= err_next;
                    seen_reg  <= seen_next;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_char_reg <= char_code;
            in_last_reg <= is_last;
        end
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

### rtl/nlp_checker.sv
module nlp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] value,
    input logic [2:0]  status
);
    import nlp_pkg::*;

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("stalled result changed");

    // Any failed literal reports a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> value == 64'd0)
        else $error("error result with nonzero value");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_RANGE)
        else $error("undefined status code");

    // Input backpressure only arises from a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
);

### verif/numeric_literal_parser_tb.sv
module numeric_literal_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nlp_pkg::*;

    // Timing and reporting limits of the run.
    localparam int IDLE_MAX       = 14;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int MAX_REPORTS    = 10;

    // Address of a register slot that does not exist.
    localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR = ADDR_W'(4);

    typedef struct {
        logic [63:0] value;
        status_t     status;
    } parse_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = 8'd0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] value;
    logic [2:0]  status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    numeric_literal_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predicted parse state, kept in step with every accepted item.
    logic          mode_signed;
    phase_t        lit_phase;
    logic          lit_negative;
    radix_t        lit_radix;
    logic [63:0]   lit_mag;
    logic          lit_overflow;
    status_t       lit_error;
    logic          lit_digits;

    parse_result_t expected_results[$];

    // Flow control shared by the sender and the result checker.
    bit no_idle = 1'b0;
    bit long_hold_req = 1'b0;

    int error_count = 0;
    int results_checked = 0;
    int chars_sent = 0;
    int literals_sent = 0;
    int quiet_cycles = 0;

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Append one character to the end of a text queue.
    function automatic void append_char(ref logic [7:0] q[$], input logic [7:0] c);
        q.insert(q.size(), c);
    endfunction

    function automatic void clear_literal();
        lit_phase    = PH_START;
        lit_negative = 1'b0;
        lit_radix    = RADIX_DEC;
        lit_mag      = 64'd0;
        lit_overflow = 1'b0;
        lit_error    = ST_OK;
        lit_digits   = 1'b0;
    endfunction

    // Value of a character as a digit of the current radix, or -1.
    function automatic int digit_of(input logic [7:0] c);
        int d;
        d = -1;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = int'(c - CH_ZERO);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            d = c - CH_LOWER_A + 10;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            d = c - CH_UPPER_A + 10;
        if (lit_radix == RADIX_BIN && d > 1)
            d = -1;
        if (lit_radix == RADIX_DEC && d > 9)
            d = -1;
        return d;
    endfunction

    // A character of the digit string: underscores are skipped, the first
    // bad digit sticks, and overflow past 64 bits is remembered.
    function automatic void body_char(input logic [7:0] c);
        int d;
        if (c == CH_UNDERSCORE)
            return;
        lit_digits = 1'b1;
        if (lit_error != ST_OK)
            return;
        d = digit_of(c);
        if (d < 0)
        begin
            lit_error = ST_BAD_DIGIT;
            return;
        end
        case (lit_radix)
            RADIX_BIN:
            begin
                if (lit_mag[63])
                    lit_overflow = 1'b1;
                lit_mag = {lit_mag[62:0], d[0]};
            end
            RADIX_HEX:
            begin
                if (lit_mag[63:60] != 4'd0)
                    lit_overflow = 1'b1;
                lit_mag = {lit_mag[59:0], d[3:0]};
            end
            default:
            begin
                if (lit_mag > DEC_LIMIT || (lit_mag == DEC_LIMIT && d > DEC_LIMIT_DIGIT))
                    lit_overflow = 1'b1;
                lit_mag = lit_mag * 64'd10 + 64'(d);
            end
        endcase
    endfunction

    // First character after the optional sign: a zero may open a prefix.
    function automatic void lead_char(input logic [7:0] c);
        if (c == CH_ZERO)
        begin
            lit_digits = 1'b1;
            lit_mag    = 64'd0;
            lit_phase  = PH_AFTER_ZERO;
        end
        else
        begin
            lit_phase = PH_BODY;
            body_char(c);
        end
    endfunction

    // Advance the predicted state by one item; the final character of a
    // literal queues the result it must produce.
    function automatic void predict_char(input logic [7:0] c, input logic last);
        parse_result_t r;
        case (lit_phase)
            PH_START:
            begin
                if (c == CH_MINUS)
                begin
                    lit_negative = 1'b1;
                    lit_phase    = PH_AFTER_SIGN;
                end
                else
                    lead_char(c);
            end
            PH_AFTER_SIGN:
                lead_char(c);
            PH_AFTER_ZERO:
            begin
                lit_phase = PH_BODY;
                if (c == CH_LOWER_B)
                begin
                    lit_radix  = RADIX_BIN;
                    lit_digits = 1'b0;
                end
                else if (c == CH_LOWER_X)
                begin
                    lit_radix  = RADIX_HEX;
                    lit_digits = 1'b0;
                end
                else
                    lit_error = ST_BAD_BASE;
            end
            default:
                body_char(c);
        endcase
        if (!last)
            return;

        r.value  = 64'd0;
        r.status = ST_OK;
        if (lit_error != ST_OK)
            r.status = lit_error;
        else if (!lit_digits)
            r.status = ST_NO_DIGITS;
        else if (!mode_signed)
        begin
            if (lit_overflow || (lit_negative && lit_mag != 64'd0))
                r.status = ST_RANGE;
            else
                r.value = lit_mag;
        end
        else if (lit_overflow)
            r.status = ST_RANGE;
        else if (!lit_negative)
        begin
            if (lit_mag[63])
                r.status = ST_RANGE;
            else
                r.value = lit_mag;
        end
        else if (lit_mag[63] && lit_mag != SIGNED_MIN_MAG)
            r.status = ST_RANGE;
        else
            r.value = 64'd0 - lit_mag;

        expected_results.insert(expected_results.size(), r);
        literals_sent++;
        clear_literal();
    endfunction

    // Offer one item and hold it until accepted, then draw the gap before
    // the next one. With no gap, valid simply stays high.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        in_valid  <= 1'b1;
        char_code <= c;
        is_last   <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        chars_sent++;
        predict_char(c, last);
        gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_literal(input logic [7:0] text[$]);
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    // Stop offering items until every queued result is back, then let the
    // pipeline settle.
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One configuration access: setup phase, then access phase, then idle.
    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        if (wr && addr == REG_SIGNED_MODE)
            mode_signed = wdata[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_mode_readback();
        logic [31:0] rd;
        apb_access(1'b0, REG_SIGNED_MODE, 32'd0, rd);
        if (rd !== {31'd0, mode_signed})
            log_error($sformatf("signed_mode read back %h, expected %0d", rd, mode_signed));
    endtask

    // Change the mode between literals, with upper data bits random.
    task automatic set_mode(input logic m);
        logic [31:0] data;
        logic [31:0] rd;
        data = $urandom;
        data[0] = m;
        wait_results_done();
        apb_access(1'b1, REG_SIGNED_MODE, data, rd);
        check_mode_readback();
    endtask

    function automatic logic [7:0] digit_char(input int d, input bit upper);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10);
    endfunction

    function automatic int max_digit(input radix_t r);
        case (r)
            RADIX_BIN: return 1;
            RADIX_HEX: return 15;
            default:   return 9;
        endcase
    endfunction

    // Digits of v in radix r, most significant first, with some underscores
    // and, for prefixed radixes, some leading zeros.
    function automatic void add_digits(ref logic [7:0] text[$], input radix_t r,
                                       input logic [63:0] v);
        logic [7:0] rev[$];
        int d;
        do
        begin
            case (r)
                RADIX_BIN:
                begin
                    d = int'(v[0]);
                    v = v >> 1;
                end
                RADIX_HEX:
                begin
                    d = int'(v[3:0]);
                    v = v >> 4;
                end
                default:
                begin
                    d = int'(v % 64'd10);
                    v = v / 64'd10;
                end
            endcase
            append_char(rev, digit_char(d, 1'($urandom_range(0, 1))));
        end
        while (v != 64'd0);
        if (r != RADIX_DEC && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) append_char(rev, CH_ZERO);
        for (int i = rev.size() - 1; i >= 0; i--)
        begin
            append_char(text, rev[i]);
            if (i > 0 && $urandom_range(0, 7) == 0)
                append_char(text, CH_UNDERSCORE);
        end
        if ($urandom_range(0, 15) == 0)
            append_char(text, CH_UNDERSCORE);
    endfunction

    // Mostly well-formed literals with random content, some of them pushed
    // past the range, some with one character spoiled, the rest noise.
    function automatic void make_literal(ref logic [7:0] text[$]);
        int kind;
        int w;
        radix_t r;
        logic [63:0] v;
        text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 78)
        begin
            if ($urandom_range(0, 1))
                append_char(text, CH_MINUS);
            case ($urandom_range(0, 2))
                0: r = RADIX_DEC;
                1: r = RADIX_BIN;
                default: r = RADIX_HEX;
            endcase
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 7))
                    0: v = 64'd0;
                    1: v = 64'd1;
                    2: v = SIGNED_MIN_MAG - 64'd1;
                    3: v = SIGNED_MIN_MAG;
                    4: v = SIGNED_MIN_MAG + 64'd1;
                    5: v = {64{1'b1}};
                    6: v = DEC_LIMIT;
                    default: v = DEC_LIMIT * 64'd10 + 64'd4;
                endcase
            end
            else
            begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                v = {$urandom, $urandom};
                v = v >> (64 - w);
            end
            if (r == RADIX_BIN)
            begin
                append_char(text, CH_ZERO);
                append_char(text, CH_LOWER_B);
            end
            else if (r == RADIX_HEX)
            begin
                append_char(text, CH_ZERO);
                append_char(text, CH_LOWER_X);
            end
            add_digits(text, r, v);
            // Extra digits push large values past 64 bits.
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2))
                    append_char(text, digit_char($urandom_range(0, max_digit(r)),
                                                 1'($urandom_range(0, 1))));
            if (kind >= 68)
                text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else
        begin
            // Noise: near-miss characters mixed with arbitrary bytes.
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 1))
                    append_char(text, 8'($urandom_range(0, 255)));
                else
                    case ($urandom_range(0, 15))
                        0:  append_char(text, CH_MINUS);
                        1:  append_char(text, CH_ZERO);
                        2:  append_char(text, CH_ZERO + 8'd1);
                        3:  append_char(text, CH_ZERO + 8'd2);
                        4:  append_char(text, CH_NINE);
                        5:  append_char(text, CH_NINE + 8'd1);
                        6:  append_char(text, CH_ZERO - 8'd1);
                        7:  append_char(text, CH_LOWER_B);
                        8:  append_char(text, CH_LOWER_X);
                        9:  append_char(text, CH_UNDERSCORE);
                        10: append_char(text, CH_LOWER_A - 8'd1);
                        11: append_char(text, CH_LOWER_F + 8'd1);
                        12: append_char(text, CH_UPPER_A - 8'd1);
                        13: append_char(text, CH_UPPER_F + 8'd1);
                        14: append_char(text, CH_UPPER_A + 8'd1);
                        default: append_char(text, CH_LOWER_X - 8'd32);
                    endcase
            end
        end
    endfunction

    // The mode register must come out of reset unsigned.
    task automatic test_reset_value();
        check_mode_readback();
    endtask

    // Prefix corner cases, lone and negative zero, misplaced signs and
    // underscores, and empty digit strings.
    task automatic test_special_cases();
        string specials[] = '{"0", "-0", "-", "0x", "0b", "0_", "07", "--1", "_",
                              "0x_", "1-", "0b2", "0xg", "9A", "-x", "0xFf"};
        logic [7:0] text[$];
        foreach (specials[k])
        begin
            text.delete();
            for (int i = 0; i < specials[k].len(); i++)
                append_char(text, specials[k][i]);
            send_literal(text);
        end
    endtask

    task automatic test_random(input int char_budget);
        logic [7:0] text[$];
        int stop_at;
        stop_at = chars_sent + char_budget;
        while (chars_sent < stop_at)
        begin
            if ($urandom_range(0, 15) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 39) == 0)
                wait_results_done();
            make_literal(text);
            send_literal(text);
        end
        no_idle = 1'b0;
    endtask

    // A write to a register slot that does not exist must leave the mode alone.
    task automatic test_ignored_index();
        logic [31:0] data;
        logic [31:0] rd;
        data = $urandom;
        data[0] = !mode_signed;
        wait_results_done();
        apb_access(1'b1, UNUSED_REG_ADDR, data, rd);
        check_mode_readback();
        test_random(40);
    endtask

    // The result side holds off for a long stretch while items keep coming,
    // so the block fills and stalls its input.
    task automatic test_backpressure();
        logic [7:0] text[$];
        wait_results_done();
        long_hold_req = 1'b1;
        no_idle = 1'b1;
        repeat (12)
        begin
            make_literal(text);
            send_literal(text);
        end
        no_idle = 1'b0;
        wait_results_done();
    endtask

    // Result side: compare each accepted result with the oldest expectation
    // and draw how long to stall before taking the next one.
    initial
    begin : result_checker
        parse_result_t want;
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                    log_error($sformatf("unexpected result: value %h status %0d",
                                        value, status));
                else
                begin
                    want = expected_results.pop_front();
                    if (value !== want.value || status !== want.status)
                        log_error($sformatf({"result %0d: expected value %h status %0d,",
                                             " got value %h status %0d"},
                                            results_checked, want.value, want.status,
                                            value, status));
                end
                hold = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
            end
            else if (hold > 0)
                hold--;
            if (long_hold_req)
            begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            out_stall <= (hold > 0);
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        mode_signed = 1'b0;
        clear_literal();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_value();
        test_special_cases();
        set_mode(1'b1);
        test_random(580);
        test_ignored_index();
        test_backpressure();
        set_mode(1'b0);
        test_random(580);
        set_mode(1'b1);
        test_special_cases();

        wait_results_done();
        repeat (8) @(posedge clk);
        $display("Ran %0d literals (%0d characters), %0d results checked, %0d errors.",
                 literals_sent, chars_sent, results_checked, error_count);
        $display("Covered both range modes, all radixes, range edges, noise and long stalls.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/nlp_pkg.sv
rtl/numeric_literal_parser.sv
rtl/nlp_checker.sv
verif/numeric_literal_parser_tb.sv
